/* hw/rtl/tvt_pkg.sv */
// ----------------------------------------------------------------------------
// tvt_pkg: shared types and constants of the thermistor converter
// Calibration table, status codes and fixed-point helper functions.
// ----------------------------------------------------------------------------
package tvt_pkg;

    // Table size and the widest table the design supports.
    localparam int TABLE_ENTRIES_DEF = 39;
    localparam int ROM_MAX           = 64;
    localparam int ROM_IDX_W         = 6;

    // Field widths.
    localparam int VOLT_W   = 16;
    localparam int TEMP_W   = 17;
    localparam int STATUS_W = 2;

    // Extended temperature width used before saturation.
    localparam int TEXT_W = 19;

    // Divider: quotient fits in 11 bits (at most 1280), remainder in 28 bits.
    localparam int QUOT_W = 11;
    localparam int REM_W  = 28;
    localparam int CNT_W  = 4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COLD = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HOT  = 2'd2;

    typedef logic [VOLT_W-1:0]        t_volt;
    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic signed [TEXT_W-1:0] t_temp_ext;

    // Calibration voltage in Q2.14 for entry idx (idx*5-40 C); zero past the data.
    function automatic t_volt cal_entry(input logic [ROM_IDX_W-1:0] idx);
        t_volt v;
        case (idx)
            6'd0:    v = 16'd52441;
            6'd1:    v = 16'd51858;
            6'd2:    v = 16'd51094;
            6'd3:    v = 16'd50111;
            6'd4:    v = 16'd48912;
            6'd5:    v = 16'd47451;
            6'd6:    v = 16'd45725;
            6'd7:    v = 16'd43687;
            6'd8:    v = 16'd41348;
            6'd9:    v = 16'd38806;
            6'd10:   v = 16'd36028;
            6'd11:   v = 16'd33084;
            6'd12:   v = 16'd30057;
            6'd13:   v = 16'd27034;
            6'd14:   v = 16'd24094;
            6'd15:   v = 16'd21305;
            6'd16:   v = 16'd18713;
            6'd17:   v = 16'd16348;
            6'd18:   v = 16'd14223;
            6'd19:   v = 16'd12335;
            6'd20:   v = 16'd10676;
            6'd21:   v = 16'd9227;
            6'd22:   v = 16'd7968;
            6'd23:   v = 16'd6880;
            6'd24:   v = 16'd5942;
            6'd25:   v = 16'd5133;
            6'd26:   v = 16'd4431;
            6'd27:   v = 16'd3833;
            6'd28:   v = 16'd3324;
            6'd29:   v = 16'd2890;
            6'd30:   v = 16'd2520;
            6'd31:   v = 16'd2203;
            6'd32:   v = 16'd1930;
            6'd33:   v = 16'd1694;
            6'd34:   v = 16'd1479;
            6'd35:   v = 16'd1294;
            6'd36:   v = 16'd1136;
            6'd37:   v = 16'd1001;
            6'd38:   v = 16'd885;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Temperature of entry idx in Q8.8: idx*1280 - 10240.
    function automatic t_temp_ext entry_temp(input logic [ROM_IDX_W-1:0] idx);
        t_temp_ext t;
        t = $signed({3'b000, idx, 10'b0}) + $signed({5'b00000, idx, 8'b0})
            - 19'sd10240;
        return t;
    endfunction

    // Clamp an extended temperature into the signed 17-bit output range.
    function automatic t_temp sat_temp(input t_temp_ext t);
        t_temp r;
        if (t > 19'sd65535) begin
            r = 17'sd65535;
        end else if (t < -19'sd65536) begin
            r = -17'sd65536;
        end else begin
            r = t[TEMP_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/thermistor_voltage_to_temperature_unit.sv */
// ----------------------------------------------------------------------------
// thermistor_voltage_to_temperature_unit: NTC divider voltage to temperature
// Binary search of a falling calibration table, then linear interpolation.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_valid, o_stall, i_sense_voltage (unsigned Q2.14 volts).
//   An item is taken at a clock edge where i_valid is high and o_stall low.
//   Output channel: o_valid, i_stall, o_temperature (signed Q8.8 degrees C)
//   and o_status (0 ok, 1 too cold, 2 too hot). A result item is delivered
//   at an edge where o_valid is high and i_stall low.
//   The unit works on one item at a time and holds o_stall high from the
//   accept until its result item has been taken.
//   Sequence: a range check, then one table probe per cycle of the binary
//   search (at most ceil(log2(TABLE_ENTRIES-1)) probes and a closing step),
//   a step to set up the divide, eleven steps of the restoring divider and
//   a step to form the result. An out-of-range voltage or an exact table
//   hit skips the rest. The divider's eleven steps dominate the conversion.
//   While i_stall is high the result registers hold their value and o_valid
//   stays high. A synchronous reset (i_rst_n low) returns the sequencer to
//   idle and drops any item in flight; the table is constant and needs none.
// ----------------------------------------------------------------------------
module thermistor_voltage_to_temperature_unit
    import tvt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [VOLT_W-1:0]        i_sense_voltage,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [TEMP_W-1:0] o_temperature,
    output logic [STATUS_W-1:0]      o_status
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // One-hot sequencer states.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RANGE  = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_LOAD   = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] FIRST_PRB = IDX_W'((TABLE_ENTRIES - 1) / 2);

    t_state                  r_state, n_state;
    t_volt                   r_volt, n_volt;
    logic [IDX_W-1:0]        r_bottom, n_bottom;
    logic [IDX_W-1:0]        r_top, n_top;
    logic [IDX_W-1:0]        r_probe, n_probe;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [REM_W-1:0]        r_dsor, n_dsor;
    logic [QUOT_W-1:0]       r_quot, n_quot;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_zero_den, n_zero_den;
    t_temp                   r_temp, n_temp;
    logic [STATUS_W-1:0]     r_status, n_status;

    // Table reads: the probe during the search, the bracket ends otherwise.
    t_volt            probe_v;
    t_volt            lo_v;
    t_volt            hi_v;
    logic [IDX_W:0]   span;
    logic [IDX_W:0]   mid_sum;
    t_volt            num;
    t_volt            den;
    logic [QUOT_W-1:0] frac;

    always_comb begin
        probe_v = cal_entry(ROM_IDX_W'(r_probe));
        lo_v    = cal_entry(ROM_IDX_W'(r_bottom));
        hi_v    = cal_entry(ROM_IDX_W'(r_top));
        span    = {1'b0, r_top} - {1'b0, r_bottom};
        num     = lo_v - r_volt;
        den     = lo_v - hi_v;
        frac    = r_zero_den ? '0 : r_quot;
    end

    always_comb begin
        n_state    = r_state;
        n_volt     = r_volt;
        n_bottom   = r_bottom;
        n_top      = r_top;
        n_probe    = r_probe;
        n_rem      = r_rem;
        n_dsor     = r_dsor;
        n_quot     = r_quot;
        n_cnt      = r_cnt;
        n_zero_den = r_zero_den;
        n_temp     = r_temp;
        n_status   = r_status;
        mid_sum    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_volt  = i_sense_voltage;
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                // Out-of-range voltages end here with a zero temperature.
                n_bottom = '0;
                n_top    = LAST_IDX;
                n_probe  = FIRST_PRB;
                if (r_volt > cal_entry(ROM_IDX_W'(0))) begin
                    n_temp   = '0;
                    n_status = STATUS_COLD;
                    n_state  = S_OUT;
                end else if (r_volt < cal_entry(ROM_IDX_W'(LAST_IDX))) begin
                    n_temp   = '0;
                    n_status = STATUS_HOT;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (span > (IDX_W + 1)'(1)) begin
                    if (r_volt > probe_v) begin
                        n_top = r_probe;
                    end else if (r_volt < probe_v) begin
                        n_bottom = r_probe;
                    end else begin
                        // Exact table hit: the entry's own temperature.
                        n_temp   = sat_temp(entry_temp(ROM_IDX_W'(r_probe)));
                        n_status = STATUS_OK;
                        n_state  = S_OUT;
                    end
                    mid_sum = {1'b0, n_top} + {1'b0, n_bottom};
                    n_probe = mid_sum[IDX_W:1];
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // Dividend num*2560 + den, divisor 2*den aligned to quotient bit 10.
                n_rem      = {1'b0, num, 11'b0} + {3'b000, num, 9'b0}
                             + {12'b0, den};
                n_dsor     = {1'b0, den, 11'b0};
                n_zero_den = (den == '0);
                n_quot     = '0;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (r_rem >= r_dsor) begin
                    n_rem  = r_rem - r_dsor;
                    n_quot = {r_quot[QUOT_W-2:0], 1'b1};
                end else begin
                    n_quot = {r_quot[QUOT_W-2:0], 1'b0};
                end
                n_dsor = r_dsor >> 1;
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_temp   = sat_temp(entry_temp(ROM_IDX_W'(r_bottom))
                                    + $signed({{(TEXT_W - QUOT_W){1'b0}}, frac}));
                n_status = STATUS_OK;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_volt     <= n_volt;
        r_bottom   <= n_bottom;
        r_top      <= n_top;
        r_probe    <= n_probe;
        r_rem      <= n_rem;
        r_dsor     <= n_dsor;
        r_quot     <= n_quot;
        r_cnt      <= n_cnt;
        r_zero_den <= n_zero_den;
        r_temp     <= n_temp;
        r_status   <= n_status;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_temperature = r_temp;
    assign o_status      = r_status;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for thermistor_voltage_to_temperature_unit
// Sends divider voltages over the valid/stall input channel, predicts each
// temperature and status with an independent table search and interpolation,
// and compares every result item in order while both sides idle at random.
// ----------------------------------------------------------------------------
module tb
    import tvt_pkg::*;
();

    localparam int TABLE_SIZE      = 39;
    localparam int STEP_Q88        = 1280;
    // Cycles with no item moving on either channel before the run is abandoned.
    // It lies well above one conversion and the longest deliberate hold on the
    // result side.
    localparam int WATCHDOG_CYCLES = 5000;
    // Quiet cycles after the last result: more than one conversion.
    localparam int DRAIN_CYCLES    = 40;

    // Nominal divider voltage per 5 degree step from -40 C, Q2.14 volts.
    localparam t_volt CAL_VOLTS [TABLE_SIZE] = '{
        16'd52441, 16'd51858, 16'd51094, 16'd50111, 16'd48912, 16'd47451,
        16'd45725, 16'd43687, 16'd41348, 16'd38806, 16'd36028, 16'd33084,
        16'd30057, 16'd27034, 16'd24094, 16'd21305, 16'd18713, 16'd16348,
        16'd14223, 16'd12335, 16'd10676, 16'd9227,  16'd7968,  16'd6880,
        16'd5942,  16'd5133,  16'd4431,  16'd3833,  16'd3324,  16'd2890,
        16'd2520,  16'd2203,  16'd1930,  16'd1694,  16'd1479,  16'd1294,
        16'd1136,  16'd1001,  16'd885
    };

    typedef struct {
        t_temp                temperature;
        logic [STATUS_W-1:0]  status;
    } t_reading;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [VOLT_W-1:0]        i_sense_voltage;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [TEMP_W-1:0] o_temperature;
    logic [STATUS_W-1:0]      o_status;

    // Readings predicted at input accept time, oldest first.
    t_reading expected_readings [$];
    int       mismatch_count = 0;

    // Idle rates in percent of cycles, changed between phases by the tests.
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    // A nonzero value asks the result side to hold off for that many cycles.
    int       hold_request  = 0;
    int       hold_left     = 0;
    int       quiet_cycles  = 0;

    thermistor_voltage_to_temperature_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sense_voltage (i_sense_voltage),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_temperature   (o_temperature),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Temperature of one table entry in Q8.8.
    function automatic int entry_degrees_q88(input int idx);
        return (idx * 5 - 40) * 256;
    endfunction

    // Predict the reading for one voltage. Out-of-range voltages give a status
    // and zero temperature. Otherwise a binary search narrows the bracket to two
    // neighbors; a probe that matches exactly returns its own temperature, and
    // anything else is interpolated across the 5 degree step with round-half-up.
    function automatic t_reading predict_temperature(input t_volt volts);
        t_reading    r;
        int          lower;
        int          upper;
        int          probe;
        bit          hit;
        int unsigned span_num;
        int unsigned span_den;
        int unsigned frac;
        r.temperature = '0;
        r.status      = STATUS_OK;
        if (volts > CAL_VOLTS[0]) begin
            r.status = STATUS_COLD;
        end else if (volts < CAL_VOLTS[TABLE_SIZE-1]) begin
            r.status = STATUS_HOT;
        end else begin
            lower = 0;
            upper = TABLE_SIZE - 1;
            probe = (TABLE_SIZE - 1) / 2;
            hit   = 1'b0;
            while (upper - lower > 1 && !hit) begin
                if (volts > CAL_VOLTS[probe]) begin
                    upper = probe;
                end else if (volts < CAL_VOLTS[probe]) begin
                    lower = probe;
                end else begin
                    hit = 1'b1;
                end
                if (!hit) begin
                    probe = (upper + lower) / 2;
                end
            end
            if (hit) begin
                r.temperature = t_temp'(entry_degrees_q88(probe));
            end else begin
                span_num = CAL_VOLTS[lower] - volts;
                span_den = CAL_VOLTS[lower] - CAL_VOLTS[upper];
                frac = (span_den == 0) ? 0 :
                       (span_num * (2 * STEP_Q88) + span_den) / (2 * span_den);
                r.temperature = t_temp'(entry_degrees_q88(lower) + int'(frac));
            end
        end
        return r;
    endfunction

    // Offer one voltage and hold it until the unit takes it. The valid line is
    // only lowered when an idle gap comes first, so back-to-back items never see
    // valid dropped and raised in the same time step.
    task automatic send_voltage(input t_volt volts);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sense_voltage <= volts;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        expected_readings.push_back(predict_temperature(volts));
    endtask

    // Random voltage, weighted toward the calibrated range and the table
    // entries themselves, where the search and the exact-hit path live.
    function automatic t_volt random_voltage();
        int    pick;
        int    idx;
        t_volt v;
        pick = $urandom_range(99);
        idx  = $urandom_range(TABLE_SIZE - 1);
        if (pick < 55) begin
            v = t_volt'($urandom_range(CAL_VOLTS[0], CAL_VOLTS[TABLE_SIZE-1]));
        end else if (pick < 70) begin
            v = CAL_VOLTS[idx];
        end else if (pick < 80) begin
            v = ($urandom_range(1)) ? CAL_VOLTS[idx] + 16'd1 : CAL_VOLTS[idx] - 16'd1;
        end else begin
            v = t_volt'($urandom_range(16'hFFFF));
        end
        return v;
    endfunction

    // Extremes of the input, both range edges and their neighbors, exact hits
    // on the first probe, inner probes and the last entry, plus in-between
    // voltages that exercise the interpolation and its rounding.
    task automatic test_directed();
        t_volt corner_volts [$];
        corner_volts = '{
            16'd0,     16'hFFFF,  16'd52441, 16'd52442, 16'd52440,
            16'd885,   16'd884,   16'd886,   16'd12335, 16'd30057,
            16'd1001,  16'd36028, 16'd5942,  16'd1000,  16'd943,
            16'd52150, 16'd45000, 16'd20000, 16'd3000,  16'h8000,
            16'h7FFF,  16'h5555,  16'hAAAA,  16'd1479,  16'd2203
        };
        foreach (corner_volts[k]) begin
            send_voltage(corner_volts[k]);
        end
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            send_voltage(random_voltage());
        end
    endtask

    // The result side holds off for a long stretch while the sender keeps
    // offering items back to back, so the unit's result waits and its input
    // stall stays up until the hold ends.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 300;
        repeat (8) begin
            send_voltage(random_voltage());
        end
    endtask

    // Result side: drives the stall line and checks every item it takes
    // against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: result item with no prediction waiting: temp %0d status %0d",
                         $time, o_temperature, o_status);
                mismatch_count++;
            end else begin
                if (o_temperature !== expected_readings[0].temperature) begin
                    $display("%0t: temperature mismatch: expected %0d actual %0d",
                             $time, expected_readings[0].temperature, o_temperature);
                    mismatch_count++;
                end
                if (o_status !== expected_readings[0].status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, expected_readings[0].status, o_status);
                    mismatch_count++;
                end
                void'(expected_readings.pop_front());
            end
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: any accept on either channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_sense_voltage <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 20;
        recv_idle_pct = 59;
        test_directed();
        test_random(185, 20, 59);
        test_random(185, 59, 20);
        test_backpressure();
        test_random(180, 0, 0);
        i_valid <= 1'b0;

        while (expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* thermistor_voltage_to_temperature_unit.f */
hw/rtl/tvt_pkg.sv
hw/rtl/thermistor_voltage_to_temperature_unit.sv
tb/tb.sv
